>>> hdl/segment_distance_z_interpolator_defines.svh
// Assertion macros for the module that checks its own behaviour.
`ifndef SEGMENT_DISTANCE_Z_INTERPOLATOR_DEFINES_SVH
`define SEGMENT_DISTANCE_Z_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SDZI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SDZI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDZI_ASSERT(lbl, clk, rstn, prop, msg)
`define SDZI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/sdzi_pkg.sv
package sdzi_pkg;

  localparam int CW   = 24;
  localparam int ZW   = 16;
  localparam int OW   = 32;
  localparam int CF   = 8;
  localparam int RF   = 16;
  localparam int DW   = CW;
  localparam int SQW  = 2 * DW + 1;
  localparam int RW   = (SQW + 1) / 2;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;
  localparam int NUMW = RW + RF + 1;
  localparam int THW  = NUMW - RF;
  localparam int PHW  = ZW + THW;
  localparam int PLW  = ZW + RF;
  localparam int ZBW  = PHW + CF + 3;
  localparam int SH   = RF - CF;
  localparam int NST  = 6 + RW + NUMW;
  localparam int NSD  = NST - 1;

  localparam logic [ZBW-1:0] RND = ZBW'(1) << (SH - 1);
  localparam logic signed [ZBW-1:0] ZMAX = (ZBW'(1) << (OW - 1)) - ZBW'(1);
  localparam logic signed [ZBW-1:0] ZMIN = -(ZBW'(1) << (OW - 1));

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [ZW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [ZW-1:0] b_z;
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
  } sdzi_in_t;

  typedef struct packed {
    logic signed [OW-1:0] z_out;
    logic                 degenerate;
  } sdzi_out_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [RW-1:0]   root;
  } sdzi_sq_t;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [RW-1:0]   rem;
    logic [RW-1:0]   dvs;
    logic [NUMW-1:0] quo;
  } sdzi_dv_t;

  typedef struct packed {
    logic signed [ZW-1:0] az;
    logic [ZW-1:0]        adz;
    logic                 dneg;
    logic                 degen;
  } sdzi_side_t;

endpackage

>>> hdl/sdzi_sqrt_cell.sv
module sdzi_sqrt_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  sdzi_pkg::sdzi_sq_t d_i,
  output sdzi_pkg::sdzi_sq_t q_o
);
  import sdzi_pkg::*;

  sdzi_sq_t        cell_d, cell_q;
  logic [REMW-1:0] part, trial;

  // One root bit per cell: bring down two radicand bits, try 4*root+1.
  always_comb begin
    part       = {d_i.rem[REMW-3:0], d_i.rad[RADW-1 -: 2]};
    trial      = {d_i.root, 2'b01};
    cell_d.rad = {d_i.rad[RADW-3:0], 2'b00};
    if (part >= trial) begin
      cell_d.rem  = part - trial;
      cell_d.root = {d_i.root[RW-2:0], 1'b1};
    end else begin
      cell_d.rem  = part;
      cell_d.root = {d_i.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;
endmodule

>>> hdl/sdzi_div_cell.sv
module sdzi_div_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  sdzi_pkg::sdzi_dv_t d_i,
  output sdzi_pkg::sdzi_dv_t q_o
);
  import sdzi_pkg::*;

  sdzi_dv_t      cell_d, cell_q;
  logic [RW:0]   part;

  // One quotient bit per cell, restoring division.
  always_comb begin
    part       = {d_i.rem, d_i.num[NUMW-1]};
    cell_d.num = {d_i.num[NUMW-2:0], 1'b0};
    cell_d.dvs = d_i.dvs;
    if (part >= {1'b0, d_i.dvs}) begin
      cell_d.rem = RW'(part - {1'b0, d_i.dvs});
      cell_d.quo = {d_i.quo[NUMW-2:0], 1'b1};
    end else begin
      cell_d.rem = part[RW-1:0];
      cell_d.quo = {d_i.quo[NUMW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;
endmodule

>>> hdl/segment_distance_z_interpolator.sv
// Throughput: one item per cycle while no result is held back; each root and quotient bit has its own cell.
// Back pressure freezes the whole pipeline while a result waits on out_stall_i.
// Reset (rst_ni, asynchronous, active low) clears all valid flags; data is not reset.
`include "segment_distance_z_interpolator_defines.svh"
module segment_distance_z_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdzi_pkg::sdzi_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdzi_pkg::sdzi_out_t out_data_o
);
  import sdzi_pkg::*;

  // Absolute difference of two signed coordinates.
  function automatic logic [DW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    d = {b[CW-1], b} - {a[CW-1], a};
    return d[CW] ? DW'(-d) : DW'(d);
  endfunction

  // The pipeline advances unless a finished result is held back.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic [NST-1:0] vld_q;
  sdzi_side_t     side_q [NSD];
  sdzi_side_t     side0_d;
  logic [ZW:0]    dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_comb begin
    dz            = {in_data_i.b_z[ZW-1], in_data_i.b_z} - {in_data_i.a_z[ZW-1], in_data_i.a_z};
    side0_d.az    = in_data_i.a_z;
    side0_d.dneg  = dz[ZW];
    side0_d.adz   = dz[ZW] ? ZW'(-dz) : ZW'(dz);
    side0_d.degen = 1'b0;
  end

  // Stage 0: absolute coordinate differences.
  logic [DW-1:0] ux_ap_q, uy_ap_q, ux_ab_q, uy_ab_q;
  // Stage 1: squares. Stage 2: squared distances.
  logic [2*DW-1:0] sxp_q, syp_q, sxb_q, syb_q;
  logic [SQW-1:0]  sap_q, sab_q, sab_d;
  sdzi_side_t      side2_d;

  assign sab_d = SQW'(sxb_q) + SQW'(syb_q);

  // The coincidence flag joins the side data as the squared length is formed.
  always_comb begin
    side2_d       = side_q[1];
    side2_d.degen = (sab_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux_ap_q <= abs_diff(in_data_i.a_x, in_data_i.p_x);
      uy_ap_q <= abs_diff(in_data_i.a_y, in_data_i.p_y);
      ux_ab_q <= abs_diff(in_data_i.a_x, in_data_i.b_x);
      uy_ab_q <= abs_diff(in_data_i.a_y, in_data_i.b_y);
      sxp_q   <= ux_ap_q * ux_ap_q;
      syp_q   <= uy_ap_q * uy_ap_q;
      sxb_q   <= ux_ab_q * ux_ab_q;
      syb_q   <= uy_ab_q * uy_ab_q;
      sap_q   <= SQW'(sxp_q) + SQW'(syp_q);
      sab_q   <= sab_d;
      for (int i = 0; i < NSD; i++) begin
        if (i == 0) begin
          side_q[i] <= side0_d;
        end else if (i == 2) begin
          side_q[i] <= side2_d;
        end else begin
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  // Square root chains for |AP| and |AB|, one cell per root bit.
  sdzi_sq_t sqa [RW+1];
  sdzi_sq_t sqb [RW+1];

  assign sqa[0] = '{rad: RADW'(sap_q), rem: '0, root: '0};
  assign sqb[0] = '{rad: RADW'(sab_q), rem: '0, root: '0};

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sdzi_sqrt_cell u_ap (.clk_i(clk_i), .en_i(adv), .d_i(sqa[k]), .q_o(sqa[k+1]));
    sdzi_sqrt_cell u_ab (.clk_i(clk_i), .en_i(adv), .d_i(sqb[k]), .q_o(sqb[k+1]));
  end

  // Rounded ratio numerator: |AP| scaled by the ratio fraction plus half of |AB|.
  logic [NUMW-1:0] num_q;
  logic [RW-1:0]   dab_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= (NUMW'(sqa[RW].root) << RF) + NUMW'(sqb[RW].root >> 1);
      dab_q <= sqb[RW].root;
    end
  end

  // Division chain, one cell per quotient bit. A zero divisor only occurs
  // for coincident endpoints, where the quotient is not used.
  sdzi_dv_t dv [NUMW+1];
  assign dv[0] = '{num: num_q, rem: '0, dvs: dab_q, quo: '0};

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    sdzi_div_cell u_div (.clk_i(clk_i), .en_i(adv), .d_i(dv[k]), .q_o(dv[k+1]));
  end

  // Integer and fraction parts of t are multiplied by |zB - zA| separately.
  logic [PHW-1:0] phi_q;
  logic [PLW-1:0] plo_q;
  sdzi_side_t     sm;
  assign sm = side_q[NSD-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      phi_q <= side_q[NSD-2].adz * dv[NUMW].quo[NUMW-1:RF];
      plo_q <= side_q[NSD-2].adz * dv[NUMW].quo[RF-1:0];
    end
  end

  // Final sum: the fraction product is rounded half up on the magnitude,
  // then the signed result is clamped to the output range.
  logic signed [ZBW-1:0] base, zsum, zsat;
  logic [ZBW-1:0]        mag;
  sdzi_out_t             out_q;

  always_comb begin
    base = ZBW'(sm.az);
    base = base <<< CF;
    mag  = (ZBW'(phi_q) << CF) + ((ZBW'(plo_q) + RND) >> SH);
    if (sm.degen) begin
      zsum = base;
    end else if (sm.dneg) begin
      zsum = base - $signed(mag);
    end else begin
      zsum = base + $signed(mag);
    end
    if (zsum > ZMAX) begin
      zsat = ZMAX;
    end else if (zsum < ZMIN) begin
      zsat = ZMIN;
    end else begin
      zsat = zsum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.z_out      <= OW'(zsat);
      out_q.degenerate <= sm.degen;
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_data_o  = out_q;

  `SDZI_ASSERT(a_stall_only_back, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output back pressure")
  `SDZI_ASSERT(a_accept_enters, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> vld_q[0], "accepted transfer lost at pipeline entry")
  `SDZI_ASSERT(a_frozen, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(vld_q), "pipeline moved under back pressure")
  `SDZI_ASSERT_ALWAYS(a_degen_whole, clk_i, (out_valid_o && out_data_o.degenerate) |-> (out_data_o.z_out[CF-1:0] == '0), "degenerate result carries a fraction")
endmodule

>>> test/tb_segment_distance_z_interpolator.sv
module tb_segment_distance_z_interpolator;
  import sdzi_pkg::*;

  // Holds the heights predicted for accepted queries and checks each result
  // against the oldest one.
  class height_board;
    sdzi_out_t pending_q[$];
    int        errors;
    int        checked;
    int        degenerate_seen;
    int        saturated_seen;

    // Integer square root, rounded down.
    function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic longint unsigned dist_sq(longint x0, longint y0, longint x1,
                                                longint y1);
      longint dx;
      longint dy;
      dx = x1 - x0;
      dy = y1 - y0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return longint'(dx * dx + dy * dy);
    endfunction

    function automatic sdzi_out_t interpolate(sdzi_in_t q);
      sdzi_out_t       r;
      longint unsigned sab;
      longint unsigned dap;
      longint unsigned dab;
      longint unsigned t;
      longint unsigned adz;
      longint unsigned mag;
      longint          base;
      longint          dz;
      longint          z;
      sab  = dist_sq(longint'(q.a_x), longint'(q.a_y), longint'(q.b_x), longint'(q.b_y));
      base = longint'(q.a_z) * (64'sd1 <<< CF);
      r.degenerate = (sab == 0);
      if (sab == 0) begin
        z = base;
      end else begin
        dap = floor_root(dist_sq(longint'(q.a_x), longint'(q.a_y), longint'(q.p_x),
                                 longint'(q.p_y)));
        dab = floor_root(sab);
        t   = ((dap << RF) + (dab >> 1)) / dab;
        dz  = longint'(q.b_z) - longint'(q.a_z);
        adz = (dz < 0) ? -dz : dz;
        mag = ((adz * (t >> RF)) << CF)
            + ((adz * (t & ((64'd1 << RF) - 1)) + (64'd1 << (SH - 1))) >> SH);
        z   = (dz < 0) ? base - longint'(mag) : base + longint'(mag);
      end
      if (z > 64'sd2147483647) z = 64'sd2147483647;
      if (z < -64'sd2147483648) z = -64'sd2147483648;
      r.z_out = z[OW-1:0];
      return r;
    endfunction

    function void note_query(sdzi_in_t q);
      pending_q.push_back(interpolate(q));
    endfunction

    function void check_height(sdzi_out_t got);
      sdzi_out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result z_out=%0d degenerate=%0b", $time, got.z_out,
                 got.degenerate);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (want.degenerate) degenerate_seen++;
      if (want.z_out == 32'h7fffffff || want.z_out == 32'h80000000) saturated_seen++;
      if (got.z_out !== want.z_out) begin
        $display("%0t: z_out mismatch expected %0d actual %0d", $time, want.z_out,
                 got.z_out);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate mismatch expected %0b actual %0b", $time,
                 want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = NST + 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  sdzi_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  sdzi_out_t out_data_o;

  height_board board;
  // Set while the receiver holds off on purpose, so that the pipeline fills.
  bit          hold_off;
  bit          stimulus_done;
  bit          ready_to_check;

  segment_distance_z_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, and runs with none at all.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] any_coord();
    logic signed [CW-1:0] c;
    case ($urandom_range(0, 5))
      0: c = 24'sh7fffff;
      1: c = 24'sh800000;
      2: c = CW'(int'($urandom_range(0, 4095)) - 2048);
      default: c = CW'($urandom());
    endcase
    return c;
  endfunction

  function automatic logic signed [ZW-1:0] any_height();
    logic signed [ZW-1:0] h;
    case ($urandom_range(0, 4))
      0: h = 16'sh7fff;
      1: h = 16'sh8000;
      2: h = ZW'(int'($urandom_range(0, 200)) - 100);
      default: h = ZW'($urandom());
    endcase
    return h;
  endfunction

  function automatic sdzi_in_t random_query();
    sdzi_in_t q;
    int       shape;
    q.a_x = any_coord();
    q.a_y = any_coord();
    q.a_z = any_height();
    q.b_z = any_height();
    shape = $urandom_range(0, 99);
    // A small share of coincident endpoints, the rest as they fall.
    if (shape < 8) begin
      q.b_x = q.a_x;
      q.b_y = q.a_y;
    end else begin
      q.b_x = any_coord();
      q.b_y = any_coord();
    end
    if (shape >= 8 && shape < 50) begin
      // Query point near the segment, as a rasteriser would give it.
      q.p_x = CW'(longint'(q.a_x) + ((longint'(q.b_x) - longint'(q.a_x))
                  * longint'(int'($urandom_range(0, 16)))) / 16);
      q.p_y = CW'(longint'(q.a_y) + ((longint'(q.b_y) - longint'(q.a_y))
                  * longint'(int'($urandom_range(0, 16)))) / 16);
    end else begin
      q.p_x = any_coord();
      q.p_y = any_coord();
    end
    if (shape >= 90) q.b_z = q.a_z;
    return q;
  endfunction

  function automatic sdzi_in_t make_query(int ax, int ay, int az, int bx, int by, int bz,
                                          int px, int py);
    sdzi_in_t q;
    q.a_x = CW'(ax);
    q.a_y = CW'(ay);
    q.a_z = ZW'(az);
    q.b_x = CW'(bx);
    q.b_y = CW'(by);
    q.b_z = ZW'(bz);
    q.p_x = CW'(px);
    q.p_y = CW'(py);
    return q;
  endfunction

  // Offers one query and holds it until the block takes it.
  task automatic send_query(sdzi_in_t q);
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_query(q);
  endtask

  task automatic send_with_gap(sdzi_in_t q);
    int gap;
    send_query(q);
    gap = gap_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= random_query();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, plus the deliberate hold-off.
  initial begin
    int stall_len;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_height(out_data_o);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_len > 0) begin
        stall_len--;
        out_stall_i <= 1'b1;
      end else begin
        stall_len = gap_length();
        out_stall_i <= (stall_len > 0);
        if (stall_len > 0) stall_len--;
      end
    end
  end

  // Long hold-off: counted here, while the sender keeps offering queries.
  initial begin
    hold_off = 1'b0;
    wait (board != null && board.checked >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3 * LATENCY) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    sdzi_in_t directed[$];
    board         = new();
    stimulus_done = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the ends of every field, coincident endpoints, equal
    // heights, P at A, at B, half way, beyond B, and far-off saturation.
    directed.push_back(make_query(0, 0, 5, 0, 0, 9, 100, 100));
    directed.push_back(make_query(-8388608, 8388607, -32768, -8388608, 8388607, 32767,
                                  0, 0));
    directed.push_back(make_query(0, 0, 10, 256, 0, 20, 0, 0));
    directed.push_back(make_query(0, 0, 10, 256, 0, 20, 256, 0));
    directed.push_back(make_query(0, 0, 10, 256, 0, 20, 128, 0));
    directed.push_back(make_query(0, 0, 10, 256, 0, -20, 1024, 0));
    directed.push_back(make_query(0, 0, 77, 512, 512, 77, -300, 40));
    directed.push_back(make_query(0, 0, -32768, 1, 0, 32767, 8388607, 8388607));
    directed.push_back(make_query(0, 0, 32767, 1, 0, -32768, -8388608, -8388608));
    directed.push_back(make_query(-8388608, -8388608, 32767, 8388607, 8388607, -32768,
                                  8388607, -8388608));
    directed.push_back(make_query(8388607, -8388608, -32768, -8388608, 8388607, 32767,
                                  0, 0));
    directed.push_back(make_query(8388607, 8388607, 0, 8388607, 8388607, 0, -8388608,
                                  -8388608));
    directed.push_back(make_query(0, 0, 3, 3, 4, 4, 3, 4));
    directed.push_back(make_query(0, 0, 1, 3, 0, 2, 1, 0));
    directed.push_back(make_query(0, 0, 1, 3, 0, 2, 2, 0));
    directed.push_back(make_query(-1, -1, -1, 1, 1, 1, 0, 0));
    directed.push_back(make_query(0, 0, 0, -1, 0, -1, -1, 0));
    directed.push_back(make_query(0, 0, 0, 8388607, 0, 1, 8388607, 0));
    foreach (directed[i]) send_with_gap(directed[i]);

    for (int n = 0; n < 2000; n++) begin
      send_with_gap(random_query());
      // Once, the sender stops until every outstanding result is back.
      if (n == 1200) wait_for_drain();
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    int waited;
    wait (stimulus_done);
    waited = 0;
    while (board.pending_q.size() != 0 && waited < 100 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (board.pending_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending_q.size());
      board.errors++;
    end
    $display("Checked %0d heights, %0d with coincident endpoints, %0d saturated.",
             board.checked, board.degenerate_seen, board.saturated_seen);
    $display("Random gaps and stalls on both sides, one long receiver hold-off.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, well clear of the slowest correct run.
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
